FILE: design/adsr_pkg.sv
package adsr_pkg;

    localparam int LEVEL_W = 17;
    localparam int TIME_W  = 32;
    localparam int DUR_W   = 16;
    localparam int CFG_W   = 17;
    localparam int PROD_W  = TIME_W + LEVEL_W;

    localparam logic [LEVEL_W-1:0] FULL_Q16 = LEVEL_W'(65536);

    localparam int DIV_STEPS = LEVEL_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [DUR_W-1:0] ATTACK_RST  = DUR_W'(170);
    localparam logic [DUR_W-1:0] DECAY_RST   = DUR_W'(70);
    localparam logic [LEVEL_W-1:0] SUSTAIN_RST = LEVEL_W'(45875);
    localparam logic [DUR_W-1:0] RELEASE_RST = DUR_W'(550);

    localparam logic [1:0] FUNC_TICK     = 2'd0;
    localparam logic [1:0] FUNC_NOTE_ON  = 2'd1;
    localparam logic [1:0] FUNC_NOTE_OFF = 2'd2;

    localparam logic [1:0] REG_ATTACK  = 2'd0;
    localparam logic [1:0] REG_DECAY   = 2'd1;
    localparam logic [1:0] REG_SUSTAIN = 2'd2;
    localparam logic [1:0] REG_RELEASE = 2'd3;

    typedef enum logic [2:0] {
        PH_WAITING = 3'd0,
        PH_START   = 3'd1,
        PH_ATTACK  = 3'd2,
        PH_DECAY   = 3'd3,
        PH_SUSTAIN = 3'd4,
        PH_RELEASE = 3'd5,
        PH_DONE    = 3'd6
    } adsr_phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL,
        ST_DIV_INIT,
        ST_DIV,
        ST_APPLY,
        ST_OUT
    } adsr_state_t;

    typedef struct packed {
        logic [1:0]         func;
        logic [TIME_W-1:0]  timestamp_mb;
        logic [LEVEL_W-1:0] note_alpha;
    } adsr_in_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [2:0]         phase;
        logic               finished;
        logic [LEVEL_W-1:0] alpha_out;
    } adsr_out_t;

    typedef struct packed {
        logic load_item;
        logic mul;
        logic div_init;
        logic div_step;
        logic apply;
        logic load_out;
    } adsr_cmd_t;

    typedef struct packed {
        logic needs_step;
        logic big;
    } adsr_status_t;

endpackage

FILE: design/adsr_dp.sv
module adsr_dp
    import adsr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  adsr_in_t           item,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  adsr_cmd_t          cmd,
    output adsr_status_t       status,
    output adsr_out_t          result
);

    logic [DUR_W-1:0]   attack_reg;
    logic [DUR_W-1:0]   decay_reg;
    logic [LEVEL_W-1:0] sustain_reg;
    logic [DUR_W-1:0]   release_reg;

    adsr_phase_t        phase_reg, phase_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [TIME_W-1:0]  last_reg, last_next;
    logic [LEVEL_W-1:0] alpha_reg, alpha_next;
    logic               finished_reg, finished_next;

    adsr_in_t           item_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [DUR_W-1:0]   rem_reg;
    logic [LEVEL_W-1:0] quo_reg;
    logic               big_reg;
    adsr_out_t          out_reg;

    logic [DUR_W-1:0]   dur_raw;
    logic [DUR_W-1:0]   divisor;
    logic [LEVEL_W-1:0] mult;
    logic [TIME_W-1:0]  dt;
    logic [DUR_W:0]     trial;
    logic               trial_ge;
    logic [LEVEL_W:0]   sum;
    logic [2*LEVEL_W-1:0] alpha_prod;

    always_comb
    begin
        unique case (phase_reg)
            PH_ATTACK:  dur_raw = attack_reg;
            PH_DECAY:   dur_raw = decay_reg;
            default:    dur_raw = release_reg;
        endcase
        divisor = (dur_raw == '0) ? DUR_W'(1) : dur_raw;
        mult = (phase_reg == PH_ATTACK) ? FULL_Q16 : (FULL_Q16 - sustain_reg);
        dt = item_reg.timestamp_mb - last_reg;
        trial = {rem_reg, quo_reg[LEVEL_W-1]};
        trial_ge = (trial >= {1'b0, divisor});
        sum = {1'b0, level_reg} + {1'b0, quo_reg};
        alpha_prod = (2*LEVEL_W)'(alpha_reg) * (2*LEVEL_W)'(level_reg);
    end

    assign status.needs_step = (item_reg.func == FUNC_TICK)
        && ((phase_reg == PH_ATTACK) || (phase_reg == PH_DECAY)
            || (phase_reg == PH_RELEASE));
    assign status.big = big_reg;
    assign result = out_reg;

    always_comb
    begin
        phase_next    = phase_reg;
        level_next    = level_reg;
        last_next     = last_reg;
        alpha_next    = alpha_reg;
        finished_next = finished_reg;
        if (cmd.apply)
        begin
            finished_next = 1'b0;
            unique case (item_reg.func)
                FUNC_TICK:
                begin
                    last_next = item_reg.timestamp_mb;
                    unique case (phase_reg)
                        PH_START:
                        begin
                            phase_next = PH_ATTACK;
                        end
                        PH_ATTACK:
                        begin
                            if (big_reg || (sum >= {1'b0, FULL_Q16}))
                            begin
                                level_next = FULL_Q16;
                                phase_next = PH_DECAY;
                            end
                            else
                            begin
                                level_next = sum[LEVEL_W-1:0];
                            end
                        end
                        PH_DECAY:
                        begin
                            if (big_reg
                                || ({1'b0, level_reg}
                                    <= ({1'b0, sustain_reg} + {1'b0, quo_reg})))
                            begin
                                level_next = sustain_reg;
                                phase_next = PH_SUSTAIN;
                            end
                            else
                            begin
                                level_next = level_reg - quo_reg;
                            end
                        end
                        PH_RELEASE:
                        begin
                            if (big_reg || (level_reg <= quo_reg))
                            begin
                                level_next    = '0;
                                phase_next    = PH_DONE;
                                finished_next = 1'b1;
                                last_next     = last_reg;
                            end
                            else
                            begin
                                level_next = level_reg - quo_reg;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                FUNC_NOTE_ON:
                begin
                    phase_next = PH_START;
                    alpha_next = (item_reg.note_alpha > FULL_Q16) ? FULL_Q16
                                                                  : item_reg.note_alpha;
                end
                FUNC_NOTE_OFF:
                begin
                    phase_next = PH_RELEASE;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg   <= ATTACK_RST;
            decay_reg    <= DECAY_RST;
            sustain_reg  <= SUSTAIN_RST;
            release_reg  <= RELEASE_RST;
            phase_reg    <= PH_WAITING;
            level_reg    <= '0;
            last_reg     <= '0;
            alpha_reg    <= FULL_Q16;
            finished_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_ATTACK:  attack_reg  <= cfg_data[DUR_W-1:0];
                    REG_DECAY:   decay_reg   <= cfg_data[DUR_W-1:0];
                    REG_SUSTAIN: sustain_reg <= (cfg_data > FULL_Q16) ? FULL_Q16 : cfg_data;
                    REG_RELEASE: release_reg <= cfg_data[DUR_W-1:0];
                    default:     attack_reg  <= attack_reg;
                endcase
            end
            phase_reg    <= phase_next;
            level_reg    <= level_next;
            last_reg     <= last_next;
            alpha_reg    <= alpha_next;
            finished_reg <= finished_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= item;
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(dt) * PROD_W'(mult);
        end
        if (cmd.div_init)
        begin
            big_reg <= (prod_reg[PROD_W-1:LEVEL_W] >= TIME_W'(divisor));
            rem_reg <= prod_reg[LEVEL_W+DUR_W-1:LEVEL_W];
            quo_reg <= prod_reg[LEVEL_W-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? DUR_W'(trial - {1'b0, divisor}) : trial[DUR_W-1:0];
            quo_reg <= {quo_reg[LEVEL_W-2:0], trial_ge};
        end
        if (cmd.load_out)
        begin
            out_reg.level     <= level_reg;
            out_reg.phase     <= phase_reg;
            out_reg.finished  <= finished_reg;
            out_reg.alpha_out <= alpha_prod[LEVEL_W+15:16];
        end
    end

endmodule

FILE: design/adsr_ctrl.sv
module adsr_ctrl
    import adsr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_ready,
    output logic         result_valid,
    input  logic         result_ready,
    input  adsr_status_t status,
    output adsr_cmd_t    cmd
);

    adsr_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             valid_reg, valid_next;

    assign result_valid = valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg && !result_ready;
        cmd        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = status.needs_step ? ST_MUL : ST_APPLY;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                if (status.big)
                begin
                    state_next = ST_APPLY;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    cnt_next     = cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    begin
                        state_next = ST_APPLY;
                    end
                end
            end
            ST_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!valid_reg || result_ready)
                begin
                    cmd.load_out = 1'b1;
                    valid_next   = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

endmodule

FILE: design/adsr_envelope_generator.sv
// ADSR envelope generator with a valid/ready input channel, a valid/ready
// result channel and a plain configuration write port.
// Each input transaction is a time tick, a note-on or a note-off, and each one
// produces exactly one result transaction carrying level, phase, finished flag
// and the note alpha scaled by the level.
// A note-on, a note-off, or a tick in a phase that does not move the level
// passes from decode straight to apply and then to output.
// A tick in attack, decay or release passes through decode, the elapsed-time
// multiply, divider setup, a 17-step restoring divider that computes the level
// step one quotient bit per cycle, apply and output. When the quotient cannot
// fit in 17 bits the step exceeds any remaining distance and the divider
// steps are skipped.
// One transaction is processed at a time; the next one is accepted in the cycle
// after the previous result is placed in the output register.
// If the receiver stalls, the result is held in the output register and the
// next transaction may still be accepted and processed, but it waits before
// writing its own result until the held one has been taken.
// Reset restores the default register values and puts the envelope in the
// waiting phase with level zero and full alpha; configure only while idle.
module adsr_envelope_generator
    import adsr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  adsr_in_t         item,
    output logic             result_valid,
    input  logic             result_ready,
    output adsr_out_t        result,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    adsr_cmd_t    cmd;
    adsr_status_t status;

    adsr_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .cmd          (cmd)
    );

    adsr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

endmodule
